FILE: rtl/kla_pkg.sv
// shared types and constants for the keypad latch and auto-repeat block
package kla_pkg;

  localparam int NumKeysDefault = 11;

  // item opcodes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_POLL   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_ALT_LAYOUT   = 2'd0;
  localparam logic [1:0] REG_ROTATED      = 2'd1;
  localparam logic [1:0] REG_FIRST_DELAY  = 2'd2;
  localparam logic [1:0] REG_REPEAT_DELAY = 2'd3;

  localparam logic [7:0] FIRST_DELAY_RESET  = 8'd30;
  localparam logic [7:0] REPEAT_DELAY_RESET = 8'd6;

  // half of the 8-bit tick circle, used for the wrap-safe due compare
  localparam logic [7:0] DUE_HALF = 8'h80;

  typedef struct packed {
    logic       alt_layout;
    logic       rotated;
    logic [7:0] first_delay;
    logic [7:0] repeat_delay;
  } cfg_t;

  typedef struct packed {
    logic sample;
    logic clear;
    logic start;
    logic step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic stop;
    logic last;
  } dp_stat_t;

endpackage

FILE: rtl/kla_regs.sv
// configuration register file behind the apb-style port
module kla_regs
  import kla_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alt_layout   <= 1'b0;
      cfg.rotated      <= 1'b0;
      cfg.first_delay  <= FIRST_DELAY_RESET;
      cfg.repeat_delay <= REPEAT_DELAY_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ALT_LAYOUT:   cfg.alt_layout   <= pwdata[0];
        REG_ROTATED:      cfg.rotated      <= pwdata[0];
        REG_FIRST_DELAY:  cfg.first_delay  <= pwdata[7:0];
        REG_REPEAT_DELAY: cfg.repeat_delay <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ALT_LAYOUT:   prdata = {31'd0, cfg.alt_layout};
      REG_ROTATED:      prdata = {31'd0, cfg.rotated};
      REG_FIRST_DELAY:  prdata = {24'd0, cfg.first_delay};
      REG_REPEAT_DELAY: prdata = {24'd0, cfg.repeat_delay};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/kla_ctrl.sv
// controller: item decode, key walk sequencing and result handshake
module kla_ctrl
  import kla_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] opcode,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = (state == ST_IDLE) && in_valid;

  always_comb begin
    cmd.sample = accept && (opcode == OP_SAMPLE);
    cmd.clear  = accept && (opcode == OP_CLEAR);
    cmd.start  = accept && (opcode == OP_POLL);
    cmd.step   = (state == ST_WALK);
    cmd.emit   = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.start) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (stat.stop || stat.last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (cmd.emit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.emit || (out_valid && out_stall);
    end
  end

`ifndef SYNTHESIS
  // a new result word only ever follows the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result word raised outside done state");

  // the input side reopens only after a result has been loaded
  a_reopen_after_emit: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) |-> $past(cmd.emit))
    else $error("input reopened without emitting a result");

  // a poll item always enters the key walk
  a_poll_walks: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == ST_WALK)
    else $error("poll item did not start the walk");
`endif

endmodule

FILE: rtl/kla_dp.sv
// datapath: scan remap, key latches, repeat timers and result registers
module kla_dp
  import kla_pkg::*;
#(
  parameter int NUM_KEYS = NumKeysDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  cfg_t        cfg,
  input  logic [15:0] raw_keys,
  input  logic [7:0]  tick,
  output logic [15:0] pressed_mask,
  output logic [15:0] held_mask,
  output logic [15:0] released_mask
);

  localparam int IdxW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_KEYS - 1);

  function automatic logic [15:0] remap_scan(input logic [15:0] k, input cfg_t c);
    logic [15:0] r;
    if (k != 16'd0 && c.alt_layout) begin
      r = ((k & 16'h0800) >> 8) | ((k & 16'h0400) >> 8) |
          ((k & 16'h0100) << 4) | ((k & 16'h0080) >> 2) |
          ((k & 16'h0040) >> 5) | ((k & 16'h0010) << 4) |
          ((k & 16'h0008) << 1) | ((k & 16'h0004) << 4) |
          ((k & 16'h0001) << 7);
    end else if (!c.rotated) begin
      r = ((k & 16'h0E00) >> 5) | ((k & 16'h0100) >> 1) |
          (k & 16'h0002) | ((k & 16'h000C) << 6) |
          ((k & 16'h00C0) >> 4) | ((k & 16'h0030) << 9);
    end else begin
      r = k;
    end
    return r;
  endfunction

  logic [15:0]     down_latch, repress_latch, release_latch, held_bits;
  logic [7:0]      due_tick [NUM_KEYS];
  logic [IdxW-1:0] idx;
  logic [7:0]      tick_q;
  logic [15:0]     pressed_acc;

  logic [15:0] scan;
  logic [3:0]  key;
  logic [15:0] key_mask;
  logic        k_down, k_rep, k_rel, k_held;
  logic [7:0]  due_diff;
  logic        not_due;
  logic        held_clr, held_set, press, wr_first, wr_repeat, stop;

  assign scan     = remap_scan(raw_keys, cfg);
  assign key      = 4'(idx) + 4'd1;
  assign key_mask = 16'd1 << key;
  assign k_down   = down_latch[key];
  assign k_rep    = repress_latch[key];
  assign k_rel    = release_latch[key];
  assign k_held   = held_bits[key];
  assign due_diff = 8'(due_tick[idx] - tick_q);
  assign not_due  = (due_diff < DUE_HALF);

  // one key per cycle; stop marks the key the walk acts on
  always_comb begin
    held_clr  = 1'b0;
    held_set  = 1'b0;
    press     = 1'b0;
    wr_first  = 1'b0;
    wr_repeat = 1'b0;
    stop      = 1'b1;
    if (!k_down) begin
      held_clr = 1'b1;
      stop     = 1'b0;
    end else if (k_rep) begin
      press    = 1'b1;
      held_set = 1'b1;
      wr_first = 1'b1;
    end else if (k_held) begin
      held_clr = k_rel;
      if (not_due) begin
        stop = 1'b0;
      end else if (!k_rel) begin
        press     = 1'b1;
        wr_repeat = 1'b1;
      end
    end else if (!k_rel) begin
      press    = 1'b1;
      held_set = 1'b1;
      wr_first = 1'b1;
    end
  end

  assign stat.stop = stop;
  assign stat.last = (idx == LastIdx);

  always_ff @(posedge clk) begin
    if (rst) begin
      down_latch    <= 16'd0;
      repress_latch <= 16'd0;
      release_latch <= 16'd0;
      held_bits     <= 16'd0;
      idx           <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        due_tick[i] <= 8'd0;
      end
    end else begin
      if (cmd.sample) begin
        down_latch    <= down_latch | scan;
        repress_latch <= repress_latch | (scan & release_latch);
        release_latch <= release_latch | (held_bits & ~scan);
      end
      if (cmd.clear || cmd.emit) begin
        down_latch    <= 16'd0;
        repress_latch <= 16'd0;
        release_latch <= 16'd0;
      end
      if (cmd.start) begin
        idx <= '0;
      end
      if (cmd.step) begin
        if (held_clr) held_bits <= held_bits & ~key_mask;
        if (held_set) held_bits <= held_bits | key_mask;
        if (wr_first) due_tick[idx] <= 8'(tick_q + cfg.first_delay);
        if (wr_repeat) due_tick[idx] <= 8'(tick_q + cfg.repeat_delay);
        if (!stat.last) idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tick_q      <= tick;
      pressed_acc <= 16'd0;
    end else if (cmd.step && press) begin
      pressed_acc <= pressed_acc | key_mask;
    end
    if (cmd.emit) begin
      pressed_mask  <= pressed_acc;
      held_mask     <= held_bits;
      released_mask <= release_latch;
    end
  end

`ifndef SYNTHESIS
  // the latches the walk reads stay put while it runs
  a_latches_stable: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> $stable(down_latch) && $stable(repress_latch) && $stable(release_latch))
    else $error("key latches changed during the walk");
`endif

endmodule

FILE: rtl/keypad_latch_autorepeat.sv
// keypad front end: latches remapped scans and reports presses with auto-repeat
// sample and clear words complete in the cycle they are accepted and give no result
// poll words: the walk steps through the keys up to the first key acted on or the last key,
//   then the result is loaded in the done state once the output side can take it
// throughput: one sample or clear word per cycle; a poll holds the input for the walk
//   and result load, stepping the due_tick timer file one key per cycle
// synchronous active-high reset clears latches, held bits, timers and valids, resets cfg
module keypad_latch_autorepeat
  import kla_pkg::*;
#(
  parameter int NUM_KEYS = NumKeysDefault
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [15:0] raw_keys,
  input  logic [7:0]  tick,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pressed_mask,
  output logic [15:0] held_mask,
  output logic [15:0] released_mask
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // layout select and repeat delays
  kla_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: decodes opcodes, runs the key walk, owns out_valid
  // the input side is held off only while a poll walks or waits to hand off its result,
  // so sample words keep flowing while an earlier result word is still pending
  kla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // latches, held bits, per-key due ticks and the result register
  kla_dp #(
    .NUM_KEYS (NUM_KEYS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg           (cfg),
    .raw_keys      (raw_keys),
    .tick          (tick),
    .pressed_mask  (pressed_mask),
    .held_mask     (held_mask),
    .released_mask (released_mask)
  );

endmodule
